// File: hdl/bfa_pkg.sv
// bfa_pkg: types, codes and helper functions of the bitmap frame allocator
// no dependencies; imported by the interfaces, the engine, the top level and the checker
package bfa_pkg;

  localparam int ADDR_IN_W      = 48;
  localparam int FRAME_ADDR_W   = 24;
  localparam int LIMIT_W        = 13;
  localparam int WORD_W         = 32;
  localparam int BIT_W          = 5;
  localparam int DEF_NUM_FRAMES = 4096;
  localparam int DEF_PAGE_BYTES = 4096;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_EXHAUSTED    = 2'd1,
    ST_OUT_OF_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_WR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [FRAME_ADDR_W-1:0] frame_address;
    status_t                 status;
  } result_t;

  // position of the lowest set bit, binary search in five steps
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] x;
    logic [BIT_W-1:0]  pos;
    x   = v;
    pos = '0;
    if (x[15:0] == 16'd0) begin
      pos[4] = 1'b1;
      x      = x >> 16;
    end
    if (x[7:0] == 8'd0) begin
      pos[3] = 1'b1;
      x      = x >> 8;
    end
    if (x[3:0] == 4'd0) begin
      pos[2] = 1'b1;
      x      = x >> 4;
    end
    if (x[1:0] == 2'd0) begin
      pos[1] = 1'b1;
      x      = x >> 2;
    end
    if (x[0] == 1'b0) begin
      pos[0] = 1'b1;
    end
    return pos;
  endfunction

endpackage

// File: hdl/bfa_if.sv
// bfa_req_if and bfa_rsp_if: valid/ready channels of the frame allocator
// depends on bfa_pkg
interface bfa_req_if;
  import bfa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [ADDR_IN_W-1:0] free_address;

  modport source (output valid, output opcode, output free_address, input ready);
  modport sink   (input valid, input opcode, input free_address, output ready);
endinterface

interface bfa_rsp_if;
  import bfa_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [FRAME_ADDR_W-1:0] frame_address;
  logic [1:0]              status;

  modport source (output valid, output frame_address, output status, input ready);
  modport sink   (input valid, input frame_address, input status, output ready);
endinterface

// File: hdl/bitmap_frame_allocator_core.sv
// allocate: bitmap words are read in order until a free bit shows up, at most
// ceil(limit / 32) words (128 at defaults); free reads the word, then writes it back; out of range skips the memory
// requests: one item at a time; the bitmap memory scan reads one word per cycle
// reset: synchronous; a clearing pass over all ceil(NUM_FRAMES / 32) bitmap words (128) marks every frame used,
// no request is taken meanwhile; frame_limit resets to 4096
module bitmap_frame_allocator_core #(
  parameter int NUM_FRAMES = bfa_pkg::DEF_NUM_FRAMES,
  parameter int PAGE_BYTES = bfa_pkg::DEF_PAGE_BYTES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [bfa_pkg::LIMIT_W-1:0] cfg_wr_data,
  bfa_req_if.sink                     req,
  bfa_rsp_if.source                   rsp
);
  import bfa_pkg::*;

  logic [LIMIT_W-1:0] frame_limit;
  logic [LIMIT_W-1:0] eff_limit;
  logic               res_valid, res_ready;
  result_t            res;
  logic               out_valid;
  result_t            out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      frame_limit <= cfg_wr_data;
    end
  end

  assign eff_limit = (32'(frame_limit) > NUM_FRAMES) ? LIMIT_W'(NUM_FRAMES) : frame_limit;

  bfa_engine #(
    .NUM_FRAMES(NUM_FRAMES),
    .PAGE_BYTES(PAGE_BYTES)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .eff_limit(eff_limit),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // output beat register
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.frame_address = out_res.frame_address;
  assign rsp.status        = out_res.status;

endmodule

// File: hdl/bfa_engine.sv
// bfa_engine: used-frame bitmap memory with its scan/free sequencer
// depends on bfa_pkg and bfa_req_if
module bfa_engine #(
  parameter int NUM_FRAMES = bfa_pkg::DEF_NUM_FRAMES,
  parameter int PAGE_BYTES = bfa_pkg::DEF_PAGE_BYTES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [bfa_pkg::LIMIT_W-1:0]  eff_limit,
  bfa_req_if.sink                      req,
  output logic                         res_valid,
  input  logic                         res_ready,
  output bfa_pkg::result_t             res
);
  import bfa_pkg::*;

  localparam int MAP_WORDS  = (NUM_FRAMES + 31) / 32;
  localparam int WADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W      = $clog2(MAP_WORDS + 1);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int IDX_W      = WADDR_W + BIT_W;
  localparam int FIDX_W     = ADDR_IN_W - PAGE_SHIFT;

  logic [WORD_W-1:0] mem [MAP_WORDS];
  logic [WORD_W-1:0] rd_data;

  state_t             state, state_next;
  logic [CNT_W-1:0]   word_cnt, word_cnt_next;
  logic               chk_valid, chk_valid_next;
  logic [WADDR_W-1:0] chk_word, chk_word_next;
  logic [WADDR_W-1:0] op_word, op_word_next;
  logic [BIT_W-1:0]   op_bit, op_bit_next;
  result_t            result, result_next;

  logic               wr_en, rd_en;
  logic [WADDR_W-1:0] wr_addr, rd_addr;
  logic [WORD_W-1:0]  wr_data;

  logic [WORD_W-1:0]           freebits;
  logic [BIT_W-1:0]            hit_bit;
  logic [IDX_W-1:0]            hit_idx;
  logic [IDX_W+PAGE_SHIFT-1:0] hit_byte;
  logic                        issue_more;
  logic [FIDX_W-1:0]           free_index;
  logic                        free_oob;

  assign freebits   = ~rd_data;
  assign hit_bit    = lowest_set(freebits);
  assign hit_idx    = {chk_word, hit_bit};
  assign hit_byte   = {hit_idx, {PAGE_SHIFT{1'b0}}};
  assign issue_more = 32'({word_cnt, {BIT_W{1'b0}}}) < 32'(eff_limit);
  assign free_index = req.free_address[ADDR_IN_W-1:PAGE_SHIFT];
  assign free_oob   = free_index >= FIDX_W'(eff_limit);
  assign res        = result;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      word_cnt  <= '0;
      chk_valid <= 1'b0;
    end else begin
      state     <= state_next;
      word_cnt  <= word_cnt_next;
      chk_valid <= chk_valid_next;
    end
    chk_word <= chk_word_next;
    op_word  <= op_word_next;
    op_bit   <= op_bit_next;
    result   <= result_next;
  end

  always_comb begin
    state_next     = state;
    word_cnt_next  = word_cnt;
    chk_valid_next = 1'b0;
    chk_word_next  = chk_word;
    op_word_next   = op_word;
    op_bit_next    = op_bit;
    result_next    = result;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    req.ready      = 1'b0;
    res_valid      = 1'b0;

    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = word_cnt[WADDR_W-1:0];
        wr_data = '1;
        if (word_cnt == CNT_W'(MAP_WORDS - 1)) begin
          word_cnt_next = '0;
          state_next    = S_IDLE;
        end else begin
          word_cnt_next = word_cnt + 1'b1;
        end
      end
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (req.opcode == OP_ALLOC) begin
            word_cnt_next = '0;
            state_next    = S_SCAN;
          end else begin
            op_word_next = req.free_address[PAGE_SHIFT+BIT_W +: WADDR_W];
            op_bit_next  = req.free_address[PAGE_SHIFT +: BIT_W];
            if (free_oob) begin
              result_next = '{frame_address: '0, status: ST_OUT_OF_RANGE};
              state_next  = S_RESP;
            end else begin
              state_next = S_FREE_RD;
            end
          end
        end
      end
      S_SCAN: begin
        if (chk_valid && (freebits != '0)) begin
          if (32'(hit_idx) < 32'(eff_limit)) begin
            wr_en       = 1'b1;
            wr_addr     = chk_word;
            wr_data     = rd_data | (WORD_W'(1) << hit_bit);
            result_next = '{frame_address: FRAME_ADDR_W'(hit_byte), status: ST_OK};
          end else begin
            result_next = '{frame_address: '0, status: ST_EXHAUSTED};
          end
          state_next = S_RESP;
        end else if (issue_more) begin
          rd_en          = 1'b1;
          rd_addr        = word_cnt[WADDR_W-1:0];
          word_cnt_next  = word_cnt + 1'b1;
          chk_valid_next = 1'b1;
          chk_word_next  = word_cnt[WADDR_W-1:0];
        end else begin
          result_next = '{frame_address: '0, status: ST_EXHAUSTED};
          state_next  = S_RESP;
        end
      end
      S_FREE_RD: begin
        rd_en      = 1'b1;
        rd_addr    = op_word;
        state_next = S_FREE_WR;
      end
      S_FREE_WR: begin
        wr_en       = 1'b1;
        wr_addr     = op_word;
        wr_data     = rd_data & ~(WORD_W'(1) << op_bit);
        result_next = '{frame_address: '0, status: ST_OK};
        state_next  = S_RESP;
      end
      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/bfa_checker.sv
// bfa_checker: port-level assertions on the frame allocator, bound to the top level
// depends on bfa_pkg and bitmap_frame_allocator_core
module bfa_checker #(
  parameter int PAGE_BYTES = bfa_pkg::DEF_PAGE_BYTES
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_ready,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic [bfa_pkg::FRAME_ADDR_W-1:0] rsp_frame_address,
  input logic [1:0]                       rsp_status
);
  import bfa_pkg::*;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  // reset starts the clearing pass with no beat pending
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("request taken or beat shown right after reset");

  a_page_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_frame_address[PAGE_SHIFT-1:0] == '0)
    else $error("frame address not page aligned");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_frame_address == '0)
    else $error("failed request returned a nonzero address");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_address)
      && $stable(rsp_status))
    else $error("stalled response beat changed");

endmodule

bind bitmap_frame_allocator_core bfa_checker #(
  .PAGE_BYTES(PAGE_BYTES)
) u_bfa_checker (
  .clk              (clk),
  .rst              (rst),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_frame_address(rsp.frame_address),
  .rsp_status       (rsp.status)
);
